// ===== hdl/diff_drive_odometry_defines.svh =====
// Assertion macros shared by the odometry block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ODO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ODO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/odo_pkg.sv =====
// Package for the differential-drive odometry block: widths, codes,
// control structs, the CORDIC arctangent table and a saturating add. No dependencies.
package odo_pkg;

    localparam int ODO_CORDIC_STEPS = 24;

    localparam int DELTA_W   = 16;
    localparam int MPS_W     = 32;
    localparam int GAIN_W    = 40;
    localparam int CFG_W     = 40;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 64;
    localparam int ANG_W     = 32;
    localparam int DIST_W    = DELTA_W + MPS_W + 1;
    localparam int DIFF_W    = DIST_W + 1;
    localparam int SPLIT     = 32;
    localparam int OP_W      = SPLIT + 1;
    localparam int ACC_W     = DIFF_W + GAIN_W;
    localparam int CS_W      = 34;
    localparam int Q_SH      = 30;
    localparam int ATAN_IDX_W = 5;

    localparam logic [ANG_W-1:0] K_Q30 = 32'h26DD3B6A;

    localparam logic [CFG_IDX_W-1:0] REG_LEFT_MPS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MPS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd2;

    localparam logic [1:0] MAC_SH0  = 2'd0;
    localparam logic [1:0] MAC_SH32 = 2'd1;
    localparam logic [1:0] MAC_SH64 = 2'd2;

    typedef struct packed {
        logic       en;
        logic       clear;
        logic [1:0] shift;
    } odo_mac_ctl_t;

    typedef struct packed {
        logic load;
        logic step;
        logic fin;
    } odo_cordic_ctl_t;

    // Rounded arctangent of 2^-i in binary angle units.
    function automatic logic [ANG_W-1:0] odo_atan(input logic [ATAN_IDX_W-1:0] i);
        logic [ANG_W-1:0] r;
        unique case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            5'd24:   r = 32'h00000029;
            5'd25:   r = 32'h00000014;
            5'd26:   r = 32'h0000000A;
            5'd27:   r = 32'h00000005;
            5'd28:   r = 32'h00000003;
            5'd29:   r = 32'h00000001;
            5'd30:   r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // 64-bit signed add that clips at the signed limits.
    function automatic logic signed [POS_W-1:0] odo_sat_add(
        input logic signed [POS_W-1:0] a,
        input logic signed [POS_W-1:0] b
    );
        logic signed [POS_W:0]   sum;
        logic signed [POS_W-1:0] r;
        sum = {a[POS_W-1], a} + {b[POS_W-1], b};
        if (sum[POS_W] != sum[POS_W-1])
        begin
            r = sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        else
        begin
            r = sum[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/odo_in_if.sv =====
// Input channel of the odometry block: wheel step deltas with valid/ready.
// Depends on odo_pkg for the field widths.
interface odo_in_if
    import odo_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [DELTA_W-1:0] left_delta;
    logic signed [DELTA_W-1:0] right_delta;

    modport source (output valid, output left_delta, output right_delta, input ready);
    modport sink   (input valid, input left_delta, input right_delta, output ready);
endinterface

// ===== hdl/odo_out_if.sv =====
// Output channel of the odometry block: pose with valid/ready.
// Depends on odo_pkg for the field widths.
interface odo_out_if
    import odo_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pose_x;
    logic signed [POS_W-1:0] pose_y;
    logic [ANG_W-1:0]        heading;

    modport source (output valid, output pose_x, output pose_y, output heading, input ready);
    modport sink   (input valid, input pose_x, input pose_y, input heading, output ready);
endinterface

// ===== hdl/odo_mac.sv =====
// Shared 33x33 signed multiplier with a 90-bit shifted accumulator.
// Depends on odo_pkg for widths, shift codes and the control struct.
module odo_mac
    import odo_pkg::*;
(
    input  logic                   clk,
    input  odo_mac_ctl_t           ctl,
    input  logic signed [OP_W-1:0] op_a,
    input  logic signed [OP_W-1:0] op_b,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [2*OP_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  addend;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    assign prod     = op_a * op_b;
    assign prod_ext = {{(ACC_W-2*OP_W){prod[2*OP_W-1]}}, prod};

    always_comb
    begin
        unique case (ctl.shift)
            MAC_SH0:  addend = prod_ext;
            MAC_SH32: addend = prod_ext <<< SPLIT;
            MAC_SH64: addend = prod_ext <<< (2*SPLIT);
            default:  addend = prod_ext;
        endcase
        acc_next = (ctl.clear ? '0 : acc_reg) + addend;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== hdl/odo_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per step command.
// Depends on odo_pkg for widths, the gain constant and the arctangent table.
module odo_cordic
    import odo_pkg::*;
(
    input  logic                   clk,
    input  odo_cordic_ctl_t        ctl,
    input  logic [ANG_W-1:0]       ang,
    input  logic [ATAN_IDX_W-1:0]  idx,
    output logic signed [OP_W-1:0] cos_q,
    output logic signed [OP_W-1:0] sin_q
);

    logic signed [CS_W-1:0] x_reg, x_next;
    logic signed [CS_W-1:0] y_reg, y_next;
    logic signed [CS_W-1:0] z_reg, z_next;
    logic                   flip_reg, flip_next;
    logic signed [CS_W-1:0] xs;
    logic signed [CS_W-1:0] ys;
    logic signed [CS_W-1:0] atan_ext;
    logic [ANG_W-1:0]       ang_fold;

    assign xs       = x_reg >>> idx;
    assign ys       = y_reg >>> idx;
    assign atan_ext = {{(CS_W-ANG_W){1'b0}}, odo_atan(idx)};

    // Angles in the left half plane are turned by half a turn first; the
    // results are negated at the end to compensate.
    assign ang_fold = {ang[ANG_W-1] ^ (ang[ANG_W-1] ^ ang[ANG_W-2]), ang[ANG_W-2:0]};

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        flip_next = flip_reg;
        if (ctl.load)
        begin
            flip_next = ang[ANG_W-1] ^ ang[ANG_W-2];
            z_next    = {{(CS_W-ANG_W){ang_fold[ANG_W-1]}}, ang_fold};
            x_next    = {{(CS_W-ANG_W){1'b0}}, K_Q30};
            y_next    = '0;
        end
        else if (ctl.step)
        begin
            if (!z_reg[CS_W-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_ext;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_ext;
            end
        end
        else if (ctl.fin)
        begin
            if (flip_reg)
            begin
                x_next = -x_reg;
                y_next = -y_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign cos_q = x_reg[OP_W-1:0];
    assign sin_q = y_reg[OP_W-1:0];

endmodule

// ===== hdl/diff_drive_odometry.sv =====
// Top level of the differential-drive odometry pose integrator.
// Depends on odo_pkg, odo_in_if, odo_out_if, odo_mac, odo_cordic and the
// assertion macros in diff_drive_odometry_defines.svh.
//
// Usage:
// - in_ch carries one transaction per odometry tick with the signed left and
//   right wheel step counts. out_ch returns one pose transaction (x, y,
//   heading) for every input transaction, in order.
// - The configuration port writes the per-wheel travel per step and the
//   heading gain; write it only while no transaction is in flight.
// - A tick with motion passes through the multiplier and CORDIC steps before
//   the pose is offered: the shared multiplier forms ten partial products in
//   turn, and the CORDIC unit does one micro-rotation per cycle. A tick with
//   both deltas zero goes straight from the idle state to the final state.
// - in_ch.ready is high only while the sequencer is idle, so the block takes
//   one transaction at a time and takes no new tick before the pose of the
//   last one has been loaded into the output register.
// - The pose sits in an output register. A new tick is accepted and worked on
//   while it waits; if the receiver still stalls when the next pose is ready,
//   the sequencer holds in its final state until the register frees up.
// - Reset clears the pose to zero and sets all configuration registers to 1.
`include "diff_drive_odometry_defines.svh"

module diff_drive_odometry
    import odo_pkg::*;
#(
    parameter int CORDIC_STEPS = ODO_CORDIC_STEPS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    odo_in_if.sink               in_ch,
    odo_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DL   = 4'd1;
    localparam logic [3:0] S_DR   = 4'd2;
    localparam logic [3:0] S_SUM  = 4'd3;
    localparam logic [3:0] S_P    = 4'd4;
    localparam logic [3:0] S_MID  = 4'd5;
    localparam logic [3:0] S_CORD = 4'd6;
    localparam logic [3:0] S_FIX  = 4'd7;
    localparam logic [3:0] S_MX   = 4'd8;
    localparam logic [3:0] S_AX   = 4'd9;
    localparam logic [3:0] S_MY   = 4'd10;
    localparam logic [3:0] S_AY   = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [MPS_W-1:0]  lmps_reg, lmps_next;
    logic [MPS_W-1:0]  rmps_reg, rmps_next;
    logic [GAIN_W-1:0] gain_reg, gain_next;

    logic signed [POS_W-1:0] x_reg, x_next;
    logic signed [POS_W-1:0] y_reg, y_next;
    logic [ANG_W-1:0]        heading_reg, heading_next;
    logic                    out_valid_reg, out_valid_next;

    logic signed [DELTA_W-1:0] ld_reg, ld_next;
    logic signed [DELTA_W-1:0] rd_reg, rd_next;
    logic signed [DIST_W-1:0]  dl_reg, dl_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic signed [DIST_W-1:0]  center_reg, center_next;
    logic [ANG_W-1:0]          dtheta_reg, dtheta_next;
    logic signed [POS_W-1:0]   out_x_reg, out_x_next;
    logic signed [POS_W-1:0]   out_y_reg, out_y_next;
    logic [ANG_W-1:0]          out_h_reg, out_h_next;

    odo_mac_ctl_t           mac_ctl;
    logic signed [OP_W-1:0] mac_a;
    logic signed [OP_W-1:0] mac_b;
    logic signed [ACC_W-1:0] acc;

    odo_cordic_ctl_t        cor_ctl;
    logic [ANG_W-1:0]       cor_ang;
    logic signed [OP_W-1:0] cos_q;
    logic signed [OP_W-1:0] sin_q;

    logic                    in_take;
    logic                    slot_free;
    logic signed [DIST_W-1:0] dr_w;
    logic signed [DIFF_W-1:0] wheel_sum;
    logic signed [POS_W-1:0] term;

    logic signed [OP_W-1:0] ld_op, rd_op, lmps_op, rmps_op;
    logic signed [OP_W-1:0] diff_lo, diff_hi, gain_lo, gain_hi;
    logic signed [OP_W-1:0] center_lo, center_hi;

    assign in_take   = in_ch.valid && in_ch.ready;
    assign slot_free = !out_valid_reg || out_ch.ready;

    assign dr_w      = acc[DIST_W-1:0];
    assign wheel_sum = {dl_reg[DIST_W-1], dl_reg} + {dr_w[DIST_W-1], dr_w};
    assign term      = {{(POS_W-(ACC_W-Q_SH)){acc[ACC_W-1]}}, acc[ACC_W-1:Q_SH]};

    // Operand pieces for the shared multiplier: low halves are unsigned, high
    // halves carry the sign except for the gain, whose high half is zero-extended.
    assign ld_op     = {{(OP_W-DELTA_W){ld_reg[DELTA_W-1]}}, ld_reg};
    assign rd_op     = {{(OP_W-DELTA_W){rd_reg[DELTA_W-1]}}, rd_reg};
    assign lmps_op   = {1'b0, lmps_reg};
    assign rmps_op   = {1'b0, rmps_reg};
    assign diff_lo   = {1'b0, diff_reg[SPLIT-1:0]};
    assign diff_hi   = {{(OP_W-(DIFF_W-SPLIT)){diff_reg[DIFF_W-1]}}, diff_reg[DIFF_W-1:SPLIT]};
    assign gain_lo   = {1'b0, gain_reg[SPLIT-1:0]};
    assign gain_hi   = {{(OP_W-(GAIN_W-SPLIT)){1'b0}}, gain_reg[GAIN_W-1:SPLIT]};
    assign center_lo = {1'b0, center_reg[SPLIT-1:0]};
    assign center_hi = {{(OP_W-(DIST_W-SPLIT)){center_reg[DIST_W-1]}},
                        center_reg[DIST_W-1:SPLIT]};

    assign cor_ang = heading_reg + acc[ANG_W+48:49];

    odo_mac u_mac (
        .clk  (clk),
        .ctl  (mac_ctl),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (acc)
    );

    odo_cordic u_cordic (
        .clk   (clk),
        .ctl   (cor_ctl),
        .ang   (cor_ang),
        .idx   (ATAN_IDX_W'(cnt_reg)),
        .cos_q (cos_q),
        .sin_q (sin_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        heading_next   = heading_reg;
        out_valid_next = out_valid_reg;
        ld_next        = ld_reg;
        rd_next        = rd_reg;
        dl_next        = dl_reg;
        diff_next      = diff_reg;
        center_next    = center_reg;
        dtheta_next    = dtheta_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_h_next     = out_h_reg;
        mac_ctl        = '{en: 1'b0, clear: 1'b0, shift: MAC_SH0};
        mac_a          = ld_op;
        mac_b          = lmps_op;
        cor_ctl        = '{load: 1'b0, step: 1'b0, fin: 1'b0};

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    ld_next = in_ch.left_delta;
                    rd_next = in_ch.right_delta;
                    if (in_ch.left_delta == '0 && in_ch.right_delta == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DL;
                    end
                end
            end
            S_DL:
            begin
                mac_ctl    = '{en: 1'b1, clear: 1'b1, shift: MAC_SH0};
                state_next = S_DR;
            end
            S_DR:
            begin
                dl_next    = acc[DIST_W-1:0];
                mac_ctl    = '{en: 1'b1, clear: 1'b1, shift: MAC_SH0};
                mac_a      = rd_op;
                mac_b      = rmps_op;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                diff_next   = {dr_w[DIST_W-1], dr_w} - {dl_reg[DIST_W-1], dl_reg};
                center_next = wheel_sum[DIFF_W-1:1];
                cnt_next    = '0;
                state_next  = S_P;
            end
            S_P:
            begin
                // Four partial products of wheel difference times gain.
                mac_ctl.en    = 1'b1;
                mac_ctl.clear = (cnt_reg[1:0] == 2'd0);
                mac_a         = cnt_reg[0] ? diff_hi : diff_lo;
                mac_b         = cnt_reg[1] ? gain_hi : gain_lo;
                case (cnt_reg[1:0])
                    2'd0:    mac_ctl.shift = MAC_SH0;
                    2'd3:    mac_ctl.shift = MAC_SH64;
                    default: mac_ctl.shift = MAC_SH32;
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    state_next = S_MID;
                end
            end
            S_MID:
            begin
                dtheta_next  = acc[ANG_W+47:48];
                cor_ctl.load = 1'b1;
                cnt_next     = '0;
                state_next   = S_CORD;
            end
            S_CORD:
            begin
                cor_ctl.step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                cor_ctl.fin = 1'b1;
                cnt_next    = '0;
                state_next  = S_MX;
            end
            S_MX, S_MY:
            begin
                mac_ctl.en    = 1'b1;
                mac_ctl.clear = !cnt_reg[0];
                mac_ctl.shift = cnt_reg[0] ? MAC_SH32 : MAC_SH0;
                mac_a         = cnt_reg[0] ? center_hi : center_lo;
                mac_b         = (state_reg == S_MX) ? cos_q : sin_q;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg[0])
                begin
                    state_next = (state_reg == S_MX) ? S_AX : S_AY;
                end
            end
            S_AX:
            begin
                x_next     = odo_sat_add(x_reg, term);
                cnt_next   = '0;
                state_next = S_MY;
            end
            S_AY:
            begin
                y_next       = odo_sat_add(y_reg, term);
                heading_next = heading_reg + dtheta_reg;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_x_next     = x_reg;
                    out_y_next     = y_reg;
                    out_h_next     = heading_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        lmps_next = lmps_reg;
        rmps_next = rmps_reg;
        gain_next = gain_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEFT_MPS:  lmps_next = cfg_data[MPS_W-1:0];
                REG_RIGHT_MPS: rmps_next = cfg_data[MPS_W-1:0];
                REG_GAIN:      gain_next = cfg_data[GAIN_W-1:0];
                default:       lmps_next = lmps_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            lmps_reg      <= MPS_W'(1);
            rmps_reg      <= MPS_W'(1);
            gain_reg      <= GAIN_W'(1);
            x_reg         <= '0;
            y_reg         <= '0;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            lmps_reg      <= lmps_next;
            rmps_reg      <= rmps_next;
            gain_reg      <= gain_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            heading_reg   <= heading_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ld_reg     <= ld_next;
        rd_reg     <= rd_next;
        dl_reg     <= dl_next;
        diff_reg   <= diff_next;
        center_reg <= center_next;
        dtheta_reg <= dtheta_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        out_h_reg  <= out_h_next;
    end

    assign in_ch.ready    = (state_reg == S_IDLE);
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.pose_x  = out_x_reg;
    assign out_ch.pose_y  = out_y_reg;
    assign out_ch.heading = out_h_reg;

    `ODO_ASSERT_NEXT(a_zero_tick_skips, in_take && in_ch.left_delta == '0 && in_ch.right_delta == '0, state_reg == S_DONE, "zero tick did not go straight to the final state")
    `ODO_ASSERT_NOW(a_pose_load_from_done, $rose(out_valid_reg), $past(state_reg) == S_DONE, "pose register loaded outside the final state")
    `ODO_ASSERT_NOW(a_cordic_count_range, state_reg == S_CORD, cnt_reg <= CNT_W'(CORDIC_STEPS - 1), "CORDIC step count out of range")
    `ODO_ASSERT_NEXT(a_pose_held_when_idle, state_reg == S_IDLE && !in_take, $stable(x_reg) && $stable(y_reg) && $stable(heading_reg), "pose changed while idle")

endmodule
